// ----- hw/rtl/wdm_pkg.sv -----
// Shared constants, types and sine table math for the wavetable DDS mixer.
package wdm_pkg;

    localparam int TABLE_SIZE_DEF    = 1000;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int NUM_CH            = 3;

    localparam int STEP_W   = 26;
    localparam int VOL_W    = 12;
    localparam int DUTY_W   = 12;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int PROD_W   = SUM_W + VOL_W + 1;
    localparam int OUT_SHIFT = 17;
    localparam int SCALED_W  = PROD_W - OUT_SHIFT;
    localparam int LEVEL_W   = SCALED_W + 1;

    localparam int MID_LEVEL = 1200;
    localparam int TOP_LEVEL = 2400;

    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(2048);

    // Queue depths: decoupling queue between front and back, and result queue.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    localparam longint unsigned SINE_AMP  = 64'd32767;
    localparam longint unsigned Q_PI_HALF = 64'h1921FB54442D1846;
    localparam int              TAYLOR_TERMS = 40;

    typedef enum logic [1:0] {
        REG_STEP_A = 2'd0,
        REG_STEP_B = 2'd1,
        REG_STEP_C = 2'd2,
        REG_VOLUME = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              valid;
        cfg_reg_t          index;
        logic [STEP_W-1:0] data;
    } cfg_wr_t;

    typedef longint unsigned taylor_div_t [TAYLOR_TERMS];

    // Term n of the sine series divides by (2n)(2n+1).
    function automatic taylor_div_t taylor_divs();
        taylor_div_t d;
        d[0] = 64'd1;
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            d[n] = longint'(2 * n) * longint'(2 * n + 1);
        end
        return d;
    endfunction

    localparam taylor_div_t TAYLOR_DIV = taylor_divs();

    // Q60 fixed-point product.
    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(32767 * sin(x)) for a Q60 angle x in [0, pi/2).
    function automatic logic [SAMPLE_W-2:0] quarter_sine(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned mag;
        x2   = qmul(x, x);
        term = x;
        acc  = x;
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            if (term != 64'd0) begin
                term = qmul(term, x2) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    acc = acc - term;
                end
                else begin
                    acc = acc + term;
                end
            end
        end
        hi  = acc >> 30;
        lo  = acc & 64'h3FFF_FFFF;
        mag = (hi * SINE_AMP + ((lo * SINE_AMP) >> 30)) >> 30;
        return mag[SAMPLE_W-2:0];
    endfunction

endpackage

// ----- hw/rtl/wavetable_dds_mixer.sv -----
// Top level of the three-channel wavetable DDS mixer producing PWM duty values.
//
// Each transfer on the input side with tick high advances three phase
// accumulators (16 fraction bits) by their step registers, looks up a signed
// sine table of TABLE_SIZE entries with the integer parts, mixes the three
// samples, scales by volume, floors by 2^17, recenters on 1200 and clamps to
// 0..2400; that value is queued as duty. A transfer with tick low is taken
// but moves no phase and yields no result. While full is low the block takes
// one item per cycle, and while results are popped it returns one result per
// cycle; a result passes the mid queue and the table read and multiply
// registers to reach the output queue, and the back end keeps four result
// slots so a stalled consumer backs up into the two-entry mid queue before
// full rises. Config writes are always ready; a step of zero also clears
// that channel's phase, and steps at or above TABLE_SIZE<<16 are clipped to
// one below. Write the configuration only while no item is in flight.
module wavetable_dds_mixer #(
    parameter int TABLE_SIZE    = wdm_pkg::TABLE_SIZE_DEF,
    parameter int FRACTION_BITS = wdm_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input queue
    input  logic                        push,
    input  logic                        tick,
    output logic                        full,
    // result queue
    output logic                        empty,
    input  logic                        pop,
    output logic [wdm_pkg::DUTY_W-1:0]  duty,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [wdm_pkg::STEP_W-1:0]  cfg_data
);

    localparam int ADDR_W   = $clog2(TABLE_SIZE);
    localparam int MIDQ_W   = wdm_pkg::NUM_CH * ADDR_W;
    localparam int MCNT_W   = $clog2(wdm_pkg::MID_DEPTH) + 1;
    localparam int OCNT_W   = $clog2(wdm_pkg::OUT_DEPTH) + 1;

    wdm_pkg::cfg_wr_t          cfg;
    logic                      midq_push;
    logic [MIDQ_W-1:0]         midq_wdata;
    logic                      midq_pop;
    logic [MIDQ_W-1:0]         midq_rdata;
    logic                      midq_full;
    logic                      midq_empty;
    logic [MCNT_W-1:0]         midq_level;
    logic [wdm_pkg::VOL_W-1:0] volume;
    logic                      res_push;
    logic [wdm_pkg::DUTY_W-1:0] res_duty;
    logic [OCNT_W-1:0]         outq_level;
    logic                      outq_full;

    // Config writes never stall: every transfer lands in a register at once.
    assign cfg_ready = 1'b1;
    always_comb
    begin
        cfg.valid = cfg_valid;
        cfg.index = wdm_pkg::cfg_reg_t'(cfg_index);
        cfg.data  = cfg_data;
    end

    // Front: classify the item, advance phases, hand table indexes forward.
    wdm_front #(
        .TABLE_SIZE   (TABLE_SIZE),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .push  (push),
        .tick  (tick),
        .q_full(midq_full),
        .full  (full),
        .q_push(midq_push),
        .q_data(midq_wdata),
        .volume(volume)
    );

    // Decoupling queue between front and back.
    wdm_fifo #(
        .WIDTH(MIDQ_W),
        .DEPTH(wdm_pkg::MID_DEPTH)
    ) u_midq (
        .clk  (clk),
        .rst_n(rst_n),
        .push (midq_push),
        .wdata(midq_wdata),
        .pop  (midq_pop),
        .rdata(midq_rdata),
        .full (midq_full),
        .empty(midq_empty),
        .level(midq_level)
    );

    // Back: lookup, mix, scale; issues only with a free result slot.
    wdm_back #(
        .TABLE_SIZE(TABLE_SIZE),
        .OUT_DEPTH (wdm_pkg::OUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (midq_empty),
        .q_data   (midq_rdata),
        .volume   (volume),
        .out_level(outq_level),
        .q_pop    (midq_pop),
        .res_push (res_push),
        .res_duty (res_duty)
    );

    // Result queue; the credit check in the back end keeps it from overflowing.
    wdm_fifo #(
        .WIDTH(wdm_pkg::DUTY_W),
        .DEPTH(wdm_pkg::OUT_DEPTH)
    ) u_outq (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push && !outq_full),
        .wdata(res_duty),
        .pop  (pop),
        .rdata(duty),
        .full (outq_full),
        .empty(empty),
        .level(outq_level)
    );

endmodule

// ----- hw/rtl/wdm_fifo.sv -----
// Small register-based queue with occupancy count.
module wdm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = PTR_W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty,
    output logic [CNT_W-1:0] level
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hw/rtl/wdm_rom.sv -----
// Sine table ROM with one registered read port, built at elaboration.
module wdm_rom #(
    parameter int TABLE_SIZE = wdm_pkg::TABLE_SIZE_DEF,
    localparam int ADDR_W = $clog2(TABLE_SIZE)
) (
    input  logic                                clk,
    input  logic [ADDR_W-1:0]                   addr,
    output logic signed [wdm_pkg::SAMPLE_W-1:0] data
);

    localparam longint unsigned SIZE_L = longint'(TABLE_SIZE);

    logic signed [wdm_pkg::SAMPLE_W-1:0] rom_c [TABLE_SIZE];
    logic signed [wdm_pkg::SAMPLE_W-1:0] data_reg;

    // Entry i is 32767*sin(2*pi*i/N): fold onto a quarter wave, then sign by half.
    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_entry
        localparam longint unsigned M    = 4 * longint'(i);
        localparam longint unsigned QUAD = M / SIZE_L;
        localparam longint unsigned REM  = M % SIZE_L;
        localparam longint unsigned R    = (QUAD % 2 == 1) ? SIZE_L - REM : REM;
        localparam longint unsigned X    = (wdm_pkg::Q_PI_HALF / SIZE_L) * R
                                         + ((wdm_pkg::Q_PI_HALF % SIZE_L) * R) / SIZE_L;
        localparam logic [wdm_pkg::SAMPLE_W-2:0] MAG =
            (R >= SIZE_L) ? wdm_pkg::SINE_AMP[wdm_pkg::SAMPLE_W-2:0]
                          : wdm_pkg::quarter_sine(X);
        localparam logic signed [wdm_pkg::SAMPLE_W-1:0] VAL =
            (QUAD >= 2) ? -$signed({1'b0, MAG}) : $signed({1'b0, MAG});
        assign rom_c[i] = VAL;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_c[addr];
    end

    assign data = data_reg;

endmodule

// ----- hw/rtl/wdm_front.sv -----
// Front end: configuration registers, phase accumulators, index generation.
module wdm_front #(
    parameter int TABLE_SIZE    = wdm_pkg::TABLE_SIZE_DEF,
    parameter int FRACTION_BITS = wdm_pkg::FRACTION_BITS_DEF,
    localparam int ADDR_W  = $clog2(TABLE_SIZE),
    localparam int PHASE_W = ADDR_W + FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wdm_pkg::cfg_wr_t                  cfg,
    input  logic                              push,
    input  logic                              tick,
    input  logic                              q_full,
    output logic                              full,
    output logic                              q_push,
    output logic [wdm_pkg::NUM_CH*ADDR_W-1:0] q_data,
    output logic [wdm_pkg::VOL_W-1:0]         volume
);

    localparam logic [wdm_pkg::STEP_W-1:0] STEP_LIMIT =
        wdm_pkg::STEP_W'((TABLE_SIZE << FRACTION_BITS) - 1);
    localparam logic [PHASE_W:0] SPAN_EXT = (PHASE_W + 1)'(TABLE_SIZE << FRACTION_BITS);

    logic [wdm_pkg::NUM_CH-1:0] step_sel;
    logic                       vol_sel;
    logic [PHASE_W-1:0]         step_sat;
    logic                       advance;
    logic [wdm_pkg::VOL_W-1:0]  volume_reg, volume_next;

    assign full    = q_full;
    assign advance = push && !q_full && tick;
    assign q_push  = advance;
    assign volume  = volume_reg;

    always_comb
    begin
        step_sel = '0;
        vol_sel  = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                wdm_pkg::REG_STEP_A: step_sel = 3'b001;
                wdm_pkg::REG_STEP_B: step_sel = 3'b010;
                wdm_pkg::REG_STEP_C: step_sel = 3'b100;
                wdm_pkg::REG_VOLUME: vol_sel  = 1'b1;
                default: ;
            endcase
        end
    end

    // Clip steps so one wrap subtraction always suffices.
    always_comb
    begin
        step_sat    = (cfg.data > STEP_LIMIT) ? STEP_LIMIT[PHASE_W-1:0]
                                              : cfg.data[PHASE_W-1:0];
        volume_next = vol_sel ? cfg.data[wdm_pkg::VOL_W-1:0] : volume_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= wdm_pkg::VOL_RESET;
        end
        else
        begin
            volume_reg <= volume_next;
        end
    end

    for (genvar ch = 0; ch < wdm_pkg::NUM_CH; ch++)
    begin : g_ch
        logic [PHASE_W-1:0] phase_reg, phase_next;
        logic [PHASE_W-1:0] step_reg, step_next;
        logic [PHASE_W:0]   acc_sum;
        logic [PHASE_W-1:0] acc_adv;

        always_comb
        begin
            acc_sum = {1'b0, phase_reg} + {1'b0, step_reg};
            acc_adv = (acc_sum >= SPAN_EXT) ? PHASE_W'(acc_sum - SPAN_EXT)
                                            : acc_sum[PHASE_W-1:0];
            phase_next = advance ? acc_adv : phase_reg;
            step_next  = step_reg;
            if (step_sel[ch])
            begin
                step_next = step_sat;
                if (step_sat == '0)
                begin
                    phase_next = '0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                phase_reg <= '0;
                step_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                step_reg  <= step_next;
            end
        end

        assign q_data[ch*ADDR_W +: ADDR_W] = acc_adv[PHASE_W-1:FRACTION_BITS];
    end

endmodule

// ----- hw/rtl/wdm_back.sv -----
// Back end: table lookups, mix and gain, scale and clamp to a duty value.
module wdm_back #(
    parameter int TABLE_SIZE = wdm_pkg::TABLE_SIZE_DEF,
    parameter int OUT_DEPTH  = wdm_pkg::OUT_DEPTH,
    localparam int ADDR_W = $clog2(TABLE_SIZE),
    localparam int OCNT_W = $clog2(OUT_DEPTH) + 1,
    localparam int CRED_W = OCNT_W + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  logic [wdm_pkg::NUM_CH*ADDR_W-1:0] q_data,
    input  logic [wdm_pkg::VOL_W-1:0]         volume,
    input  logic [OCNT_W-1:0]                 out_level,
    output logic                              q_pop,
    output logic                              res_push,
    output logic [wdm_pkg::DUTY_W-1:0]        res_duty
);

    logic signed [wdm_pkg::SAMPLE_W-1:0] samp [wdm_pkg::NUM_CH];
    logic                                v1_reg;
    logic                                v2_reg;
    logic signed [wdm_pkg::SUM_W-1:0]    mix_sum;
    logic signed [wdm_pkg::PROD_W-1:0]   prod_reg;
    logic signed [wdm_pkg::SCALED_W-1:0] scaled;
    logic signed [wdm_pkg::LEVEL_W-1:0]  level;
    logic [CRED_W-1:0]                   in_flight;

    // Pop only when the result queue has room for everything already in flight.
    assign in_flight = CRED_W'(out_level) + CRED_W'(v1_reg) + CRED_W'(v2_reg);
    assign q_pop     = !q_empty && (in_flight < CRED_W'(OUT_DEPTH));

    for (genvar ch = 0; ch < wdm_pkg::NUM_CH; ch++)
    begin : g_rom
        wdm_rom #(
            .TABLE_SIZE(TABLE_SIZE)
        ) u_rom (
            .clk (clk),
            .addr(q_data[ch*ADDR_W +: ADDR_W]),
            .data(samp[ch])
        );
    end

    assign mix_sum = wdm_pkg::SUM_W'(samp[0]) + wdm_pkg::SUM_W'(samp[1])
                   + wdm_pkg::SUM_W'(samp[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= wdm_pkg::PROD_W'(mix_sum * $signed({1'b0, volume}));
    end

    // Floor shift, recenter, clamp.
    always_comb
    begin
        scaled = prod_reg[wdm_pkg::PROD_W-1:wdm_pkg::OUT_SHIFT];
        level  = wdm_pkg::LEVEL_W'(scaled) + wdm_pkg::LEVEL_W'(wdm_pkg::MID_LEVEL);
        if (level[wdm_pkg::LEVEL_W-1])
        begin
            res_duty = '0;
        end
        else if (level > wdm_pkg::LEVEL_W'(wdm_pkg::TOP_LEVEL))
        begin
            res_duty = wdm_pkg::DUTY_W'(wdm_pkg::TOP_LEVEL);
        end
        else
        begin
            res_duty = level[wdm_pkg::DUTY_W-1:0];
        end
    end

    assign res_push = v2_reg;

endmodule

// ----- hw/rtl/wdm_checker.sv -----
// Port-level checks for the wavetable DDS mixer, bound to the top level.
module wdm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [wdm_pkg::DUTY_W-1:0] duty
);

    // Duty always within the clamp range.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (duty <= wdm_pkg::DUTY_W'(wdm_pkg::TOP_LEVEL)))
        else $error("duty above clamp limit");

    // Held result stays put until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(duty)))
        else $error("waiting result changed or vanished");

    // Full can only rise after an input transfer.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an input transfer");

    // In reset both queues read as drained.
    a_reset_state: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("queues not drained during reset");

endmodule

bind wavetable_dds_mixer wdm_checker u_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the three-channel wavetable DDS mixer.
module tb;

    localparam int TS           = wdm_pkg::TABLE_SIZE_DEF;
    localparam int FB           = wdm_pkg::FRACTION_BITS_DEF;
    localparam int unsigned SPAN      = TS << FB;
    localparam int unsigned STEP_LIMIT = SPAN - 1;
    localparam logic [wdm_pkg::STEP_W-1:0] QUARTER_STEP = wdm_pkg::STEP_W'((TS / 4) << FB);
    localparam logic [wdm_pkg::STEP_W-1:0] STEP_TOP     = wdm_pkg::STEP_W'(STEP_LIMIT);
    localparam logic [wdm_pkg::STEP_W-1:0] STEP_ALL_ONES = '1;
    localparam logic [wdm_pkg::STEP_W-1:0] VOL_TOP      = wdm_pkg::STEP_W'(4095);
    localparam int RANDOM_SETTINGS = 12;
    localparam int TICKS_PER_SETTING = 135;

    // Predicts the duty stream: keeps its own sine table, phases, steps and
    // volume, and holds the duty values still owed by the block.
    class duty_tracker;
        shortint                    wave [TS];
        int unsigned                phase [wdm_pkg::NUM_CH];
        int unsigned                step [wdm_pkg::NUM_CH];
        logic [wdm_pkg::VOL_W-1:0]  volume;
        logic [wdm_pkg::DUTY_W-1:0] duty_q [$];
        int                         errors;
        int                         checked;

        function new();
            int unsigned m;
            int unsigned quad;
            int unsigned rem;
            int unsigned mag;
            for (int i = 0; i < TS; i++)
            begin
                m    = 4 * i;
                quad = m / TS;
                rem  = m % TS;
                mag  = (quad % 2 == 1) ? sine_mag(TS - rem) : sine_mag(rem);
                wave[i] = (quad >= 2) ? -shortint'(mag) : shortint'(mag);
            end
            for (int ch = 0; ch < wdm_pkg::NUM_CH; ch++)
            begin
                phase[ch] = 0;
                step[ch]  = 0;
            end
            volume  = wdm_pkg::VOL_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        // Q60 product, upper bits kept.
        function longint unsigned q60_mul(longint unsigned a, longint unsigned b);
            logic [127:0] w;
            w = 128'(a) * 128'(b);
            return 64'(w >> 60);
        endfunction

        // floor(32767 * sin(pi/2 * r / TS)) by a Q60 Taylor series.
        function int unsigned sine_mag(int unsigned r);
            longint unsigned ang;
            longint unsigned ang2;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned hi;
            longint unsigned lo;
            longint unsigned half_pi;
            longint unsigned ts64;
            longint unsigned amp;
            half_pi = 64'h1921FB54442D1846;
            ts64    = 64'(TS);
            amp     = 64'd32767;
            if (r == 0)
                return 0;
            if (r >= TS)
                return 32767;
            ang  = (half_pi / ts64) * 64'(r) + ((half_pi % ts64) * 64'(r)) / ts64;
            ang2 = q60_mul(ang, ang);
            term = ang;
            acc  = ang;
            for (int n = 1; n < 40 && term != 0; n++)
            begin
                term = q60_mul(term, ang2) / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            hi = acc >> 30;
            lo = acc & 64'h3FFF_FFFF;
            return int'((hi * amp + ((lo * amp) >> 30)) >> 30);
        endfunction

        function void set_reg(wdm_pkg::cfg_reg_t which, logic [wdm_pkg::STEP_W-1:0] data);
            int unsigned s;
            if (which == wdm_pkg::REG_VOLUME)
            begin
                volume = data[wdm_pkg::VOL_W-1:0];
                return;
            end
            s = data;
            if (s > STEP_LIMIT)
                s = STEP_LIMIT;
            step[which] = s;
            if (s == 0)
                phase[which] = 0;
        endfunction

        // Note one accepted input transfer; a tick advances all channels and
        // owes one duty value.
        function void advance_sample(bit t);
            longint      mix;
            longint      level;
            int unsigned p;
            int unsigned idx;
            if (!t)
                return;
            mix = 0;
            for (int ch = 0; ch < wdm_pkg::NUM_CH; ch++)
            begin
                p = phase[ch] + step[ch];
                if ((p >> FB) >= TS)
                    p = p - SPAN;
                phase[ch] = p;
                idx = p >> FB;
                if (idx >= TS)
                    idx = 0;
                mix = mix + longint'(wave[idx]);
            end
            level = ((mix * longint'(volume)) >>> wdm_pkg::OUT_SHIFT) + wdm_pkg::MID_LEVEL;
            if (level > wdm_pkg::TOP_LEVEL)
                level = wdm_pkg::TOP_LEVEL;
            else if (level < 0)
                level = 0;
            duty_q.push_back(wdm_pkg::DUTY_W'(level));
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_duty(logic [wdm_pkg::DUTY_W-1:0] got);
            logic [wdm_pkg::DUTY_W-1:0] want;
            if (duty_q.size() == 0)
            begin
                report($sformatf("duty %0d popped with nothing owed", got));
                return;
            end
            want = duty_q.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("duty %0d, predicted %0d (result %0d)", got, want, checked));
        endtask

        function int pending();
            return duty_q.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b1;
    logic                          push = 1'b0;
    logic                          tick = 1'b0;
    logic                          full;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [wdm_pkg::DUTY_W-1:0]    duty;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = 2'd0;
    logic [wdm_pkg::STEP_W-1:0]    cfg_data = '0;

    // Set to suppress idling on both sides for a whole register setting.
    logic                calm = 1'b0;
    int                  pop_hold = 0;

    duty_tracker sb = new();

    int n_ticks = 0;
    int n_quiet = 0;
    int n_writes = 0;
    int n_settings = 0;

    wavetable_dds_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .tick      (tick),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .duty      (duty),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check every popped duty against the oldest prediction,
    // then pick pop for the next edge. Stalls come as short random bursts,
    // long enough to back the result queue up into full.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_duty(duty);
            if (pop_hold != 0)
            begin
                pop_hold <= pop_hold - 1;
                pop      <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 2)
            begin
                pop_hold <= $urandom_range(0, 5);
                pop      <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one input item and hold it until the transfer happens. An
    // occasional gap goes in front of it unless calm is set.
    task automatic send_tick(input bit t);
        if (!calm && $urandom_range(0, 99) < 2)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        tick <= t;
        do @(posedge clk); while (full);
        sb.advance_sample(t);
        if (t)
            n_ticks++;
        else
            n_quiet++;
    endtask

    // Hold one register write until the transfer. Valid stays high so that
    // writes can go back to back; the caller drops it after the last one.
    task automatic write_cfg(input wdm_pkg::cfg_reg_t which,
                             input logic [wdm_pkg::STEP_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(which, data);
        n_writes++;
    endtask

    // Stop offering items, wait for every owed duty, then let the pipe run
    // dry: a tick-low item in flight produces nothing to wait on.
    task automatic settle();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [wdm_pkg::STEP_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return STEP_TOP;
            2: return wdm_pkg::STEP_W'($urandom_range(67108863, STEP_LIMIT + 1));
            3: return wdm_pkg::STEP_W'($urandom_range(1, 1 << FB));
            default: return wdm_pkg::STEP_W'($urandom_range(1, STEP_LIMIT));
        endcase
    endfunction

    function automatic logic [wdm_pkg::STEP_W-1:0] pick_volume();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VOL_TOP;
            default: return wdm_pkg::STEP_W'($urandom_range(0, 4095));
        endcase
    endfunction

    initial
    begin
        int start;
        int sent;
        bit wrote;
        bit t;
        wdm_pkg::cfg_reg_t which;

        // Assert reset before the first edge so the block leaves X at once.
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: steps zero, so every tick gives the midpoint.
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        settle();
        n_settings++;

        // Quarter-table step on channel A alone walks the exact quarter
        // points and wraps back to entry zero on the fourth tick.
        write_cfg(wdm_pkg::REG_STEP_A, QUARTER_STEP);
        write_cfg(wdm_pkg::REG_VOLUME, VOL_TOP);
        cfg_valid <= 1'b0;
        repeat (4) send_tick(1'b1);
        settle();
        n_settings++;

        // All three channels in step at full volume: drive both clamps.
        write_cfg(wdm_pkg::REG_STEP_B, QUARTER_STEP);
        write_cfg(wdm_pkg::REG_STEP_C, QUARTER_STEP);
        cfg_valid <= 1'b0;
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
        repeat (2) send_tick(1'b1);
        settle();
        n_settings++;

        // Oversized step gets clipped, top and minimum steps, volume zero.
        write_cfg(wdm_pkg::REG_STEP_A, STEP_ALL_ONES);
        write_cfg(wdm_pkg::REG_STEP_B, STEP_TOP);
        write_cfg(wdm_pkg::REG_STEP_C, wdm_pkg::STEP_W'(1));
        write_cfg(wdm_pkg::REG_VOLUME, '0);
        cfg_valid <= 1'b0;
        repeat (3) send_tick(1'b1);
        settle();
        n_settings++;

        // Zero step clears channel B's phase; the nonzero step after it
        // must start from there.
        write_cfg(wdm_pkg::REG_STEP_B, '0);
        write_cfg(wdm_pkg::REG_STEP_B, wdm_pkg::STEP_W'(123457));
        write_cfg(wdm_pkg::REG_VOLUME, VOL_TOP);
        cfg_valid <= 1'b0;
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        settle();
        n_settings++;

        // Random settings: rewrite a random subset of registers, starting at
        // a random index, then stream ticks with some tick-low items mixed in.
        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            calm <= (s == 3);
            start = $urandom_range(0, 3);
            wrote = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                which = wdm_pkg::cfg_reg_t'((start + k) % 4);
                if ($urandom_range(0, 1) == 1)
                begin
                    if (which == wdm_pkg::REG_VOLUME)
                        write_cfg(which, pick_volume());
                    else
                        write_cfg(which, pick_step());
                    wrote = 1'b1;
                end
            end
            if (!wrote)
                write_cfg(wdm_pkg::REG_VOLUME, pick_volume());
            cfg_valid <= 1'b0;
            sent = 0;
            while (sent < TICKS_PER_SETTING)
            begin
                t = ($urandom_range(0, 9) != 0);
                send_tick(t);
                if (t)
                    sent++;
            end
            settle();
            n_settings++;
        end
        calm <= 1'b0;

        if (sb.pending() != 0)
            sb.report($sformatf("%0d duty values never arrived", sb.pending()));

        $display("Sent %0d ticks and %0d tick-low items across %0d register settings.",
                 n_ticks, n_quiet, n_settings);
        $display("Made %0d register writes, checked %0d duty values, %0d mismatches.",
                 n_writes, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("Run did not finish within its time budget");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
